>>> rtl/fcst_pkg.sv
// Shared types and constants for the fault code status table.
package fcst_pkg;

  // Field widths of one request and one result
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_IN_W = 7;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CNT_OUT_W = 8;

  // Packed stream widths, rounded up to whole bytes
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 72;

  // Request kinds carried on s_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_INIT     = 3'd0,
    REQ_REGISTER = 3'd1,
    REQ_FIND     = 3'd2,
    REQ_SET      = 3'd3,
    REQ_CLEAR    = 3'd4,
    REQ_COUNT    = 3'd5,
    REQ_GET_IDX  = 3'd6,
    REQ_GET_CNT  = 3'd7
  } req_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_NOT_INIT  = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5
  } res_t;

endpackage

>>> rtl/fault_code_status_table_unit.sv
// Fault code status table: request sequencer, entry memories and result register.
// Enable, get-count and rejected requests go straight to the result state; find, set-status,
// register and count-by-mask walk the stored entries one per cycle through the single
// compare unit; clear-all walks the entries, zeroing each status; get-by-index reads the
// addressed entry through the registered memory read before the result state.
// Throughput: one request in flight; the next is accepted once the result is in the output
// register. Reset clears the sequencer, the enable flag and the entry count; memories keep data.
module fault_code_status_table_unit
  import fcst_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: fault_code[31:0], severity[39:32], new_status[47:40], match_mask[55:48],
  //          entry_index[62:56], zero[63]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: req_type[2:0]
  input  logic [REQ_W-1:0]     s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: result_status[2:0], result_code[34:3], result_entry_state[42:35],
  //          result_severity[50:43], hit_index[57:51], result_count[65:58], zero[71:66]
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CLEAR = 6'b000100,
    S_IDX   = 6'b001000,
    S_IDXRD = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  // Control state
  logic             enabled;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] scan_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [CNT_W-1:0] acc;

  // Latched request
  req_t                op;
  logic [CODE_W-1:0]   code_r;
  logic [BYTE_W-1:0]   sev_r;
  logic [BYTE_W-1:0]   nstat_r;
  logic [BYTE_W-1:0]   mask_r;
  logic [IDX_IN_W-1:0] idx_r;

  // Result under construction
  res_t                 res_status;
  logic [CODE_W-1:0]    res_code;
  logic [BYTE_W-1:0]    res_sbyte;
  logic [BYTE_W-1:0]    res_sev;
  logic [IDX_IN_W-1:0]  res_hit;
  logic [CNT_OUT_W-1:0] res_cnt;

  // Entry memories and their registered read data
  logic [CODE_W-1:0] code_mem   [MAX_ENTRIES];
  logic [BYTE_W-1:0] status_mem [MAX_ENTRIES];
  logic [BYTE_W-1:0] sev_mem    [MAX_ENTRIES];
  logic [CODE_W-1:0] code_q;
  logic [BYTE_W-1:0] status_q;
  logic [BYTE_W-1:0] sev_q;

  // Input field views
  req_t                req_in;
  logic [CODE_W-1:0]   code_in;
  logic [BYTE_W-1:0]   sev_in;
  logic [BYTE_W-1:0]   nstat_in;
  logic [BYTE_W-1:0]   mask_in;
  logic [IDX_IN_W-1:0] idx_in;

  assign req_in   = req_t'(s_tuser);
  assign code_in  = s_tdata[31:0];
  assign sev_in   = s_tdata[39:32];
  assign nstat_in = s_tdata[47:40];
  assign mask_in  = s_tdata[55:48];
  assign idx_in   = s_tdata[62:56];

  logic s_fire;
  logic out_free;
  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Shared compare unit and scan control
  logic issue;
  logic code_hit;
  logic mask_hit;
  logic scan_end;
  logic full;
  logic idx_bad;
  assign issue    = (scan_idx < entry_count);
  assign code_hit = pend && (code_q == code_r);
  assign mask_hit = pend && ((status_q & mask_r) != '0);
  assign scan_end = !pend && !issue;
  assign full     = (entry_count == CNT_W'(MAX_ENTRIES));
  assign idx_bad  = (CMP_W'(idx_in) >= CMP_W'(entry_count));

  // Decode an accepted request into its first state and early result
  state_t               dec_state;
  res_t                 dec_status;
  logic [CNT_OUT_W-1:0] dec_cnt;
  logic                 dec_enable;

  always_comb begin
    dec_state  = S_OUT;
    dec_status = ST_OK;
    dec_cnt    = '0;
    dec_enable = 1'b0;
    if (req_in == REQ_INIT) begin
      if (enabled) begin
        dec_status = ST_ALREADY;
      end else begin
        dec_enable = 1'b1;
      end
    end else if (!enabled) begin
      dec_status = ST_NOT_INIT;
    end else begin
      case (req_in)
        REQ_REGISTER: begin
          if (code_in == '0) begin
            dec_status = ST_INVALID;
          end else if (full) begin
            dec_status = ST_FULL;
          end else begin
            dec_state = S_SCAN;
          end
        end
        REQ_FIND, REQ_SET, REQ_COUNT: begin
          dec_state = S_SCAN;
        end
        REQ_CLEAR: begin
          dec_state = S_CLEAR;
        end
        REQ_GET_IDX: begin
          if (idx_bad) begin
            dec_status = ST_NOT_FOUND;
          end else begin
            dec_state = S_IDX;
          end
        end
        REQ_GET_CNT: begin
          dec_cnt = CNT_OUT_W'(entry_count);
        end
        default: begin
          dec_status = ST_OK;
        end
      endcase
    end
  end

  // Memory write and read port selection
  logic             reg_commit;
  logic             set_write;
  logic             clr_write;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [BYTE_W-1:0] wr_status;

  always_comb begin
    reg_commit = (state == S_SCAN) && (op == REQ_REGISTER) && scan_end;
    set_write  = (state == S_SCAN) && (op == REQ_SET) && code_hit;
    clr_write  = (state == S_CLEAR) && issue;
    if (reg_commit) begin
      wr_addr = entry_count[IDX_W-1:0];
    end else if (set_write) begin
      wr_addr = pend_idx;
    end else begin
      wr_addr = scan_idx[IDX_W-1:0];
    end
    wr_status = set_write ? nstat_r : '0;
    rd_addr   = (state == S_IDX) ? IDX_W'(idx_r) : scan_idx[IDX_W-1:0];
  end

  // Write entries
  always_ff @(posedge clk) begin
    if (reg_commit) begin
      code_mem[wr_addr] <= code_r;
      sev_mem[wr_addr]  <= sev_r;
    end
    if (reg_commit || set_write || clr_write) begin
      status_mem[wr_addr] <= wr_status;
    end
  end

  // Read entries, one address per cycle
  always_ff @(posedge clk) begin
    code_q   <= code_mem[rd_addr];
    status_q <= status_mem[rd_addr];
    sev_q    <= sev_mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enabled     <= 1'b0;
      entry_count <= '0;
      scan_idx    <= '0;
      pend        <= 1'b0;
      acc         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            // Latch the request and start the result from its decode
            op         <= req_in;
            code_r     <= code_in;
            sev_r      <= sev_in;
            nstat_r    <= nstat_in;
            mask_r     <= mask_in;
            idx_r      <= idx_in;
            res_status <= dec_status;
            res_code   <= '0;
            res_sbyte  <= '0;
            res_sev    <= '0;
            res_hit    <= '0;
            res_cnt    <= dec_cnt;
            scan_idx   <= '0;
            pend       <= 1'b0;
            acc        <= '0;
            state      <= dec_state;
            if (dec_enable) begin
              enabled     <= 1'b1;
              entry_count <= '0;
            end
          end
        end
        S_SCAN: begin
          if (code_hit && (op != REQ_COUNT)) begin
            // Stop on the first matching code
            state <= S_OUT;
            case (op)
              REQ_REGISTER: res_status <= ST_INVALID;
              REQ_FIND: begin
                res_code  <= code_q;
                res_sbyte <= status_q;
                res_sev   <= sev_q;
                res_hit   <= IDX_IN_W'(pend_idx);
              end
              default: res_status <= ST_OK;
            endcase
          end else if (scan_end) begin
            // Walked every entry without a hit
            state <= S_OUT;
            case (op)
              REQ_REGISTER: entry_count <= entry_count + 1'b1;
              REQ_FIND, REQ_SET: res_status <= ST_NOT_FOUND;
              REQ_COUNT: res_cnt <= CNT_OUT_W'(acc);
              default: res_status <= ST_OK;
            endcase
          end else begin
            // Advance the read pointer and tally mask matches
            pend     <= issue;
            pend_idx <= scan_idx[IDX_W-1:0];
            if (issue) begin
              scan_idx <= scan_idx + 1'b1;
            end
            if (mask_hit) begin
              acc <= acc + 1'b1;
            end
          end
        end
        S_CLEAR: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end else begin
            state <= S_OUT;
          end
        end
        S_IDX: begin
          state <= S_IDXRD;
        end
        S_IDXRD: begin
          res_code  <= code_q;
          res_sbyte <= status_q;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_tdata <= {6'b0, res_cnt, res_hit, res_sev, res_sbyte, res_code, res_status};
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds table capacity");

  a_entries_need_enable: assert property (@(posedge clk) disable iff (rst)
    (entry_count != '0) |-> enabled)
    else $error("entries present while table not enabled");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && pend) |-> (CNT_W'(pend_idx) < entry_count))
    else $error("scan compared an entry beyond the entry count");

  a_result_after_out: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && out_free) |=> (m_tvalid && (state == S_IDLE)))
    else $error("result not loaded after sequencer finished");

endmodule

>>> dv/fcst_result_checker.sv
// Checker for the fault code status table: predicts each result and compares it.
`timescale 1ns / 1ps

module fcst_result_checker
  import fcst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [REQ_W-1:0]     s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  output logic [31:0]          mismatches,
  output logic [31:0]          pending
);

  typedef struct packed {
    res_t        status;
    logic [31:0] code;
    logic [7:0]  entry_state;
    logic [7:0]  severity;
    logic [6:0]  hit;
    logic [7:0]  count;
  } table_result_t;

  // Shadow copy of the table
  logic        table_on;
  int unsigned n_entries;
  logic [31:0] code_mem   [TABLE_DEPTH];
  logic [7:0]  status_mem [TABLE_DEPTH];
  logic [7:0]  sev_mem    [TABLE_DEPTH];

  table_result_t expected_responses[$];

  // Position of a stored code, -1 when absent
  function automatic int slot_of(logic [31:0] code);
    for (int unsigned i = 0; i < n_entries && i < TABLE_DEPTH; i++) begin
      if (code_mem[i] == code) return int'(i);
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the result it gives
  function automatic table_result_t predict_table_response(req_t op,
                                                           logic [S_TDATA_W-1:0] d);
    table_result_t r;
    logic [31:0]   code;
    logic [7:0]    sev;
    logic [7:0]    nstat;
    logic [7:0]    mask;
    logic [6:0]    idx;
    int            pos;
    r      = '0;
    code   = d[31:0];
    sev    = d[39:32];
    nstat  = d[47:40];
    mask   = d[55:48];
    idx    = d[62:56];
    r.status = ST_OK;
    if (op == REQ_INIT) begin
      if (table_on) begin
        r.status = ST_ALREADY;
      end else begin
        for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
          code_mem[i]   = '0;
          status_mem[i] = '0;
          sev_mem[i]    = '0;
        end
        n_entries = 0;
        table_on  = 1'b1;
      end
    end else if (!table_on) begin
      r.status = ST_NOT_INIT;
    end else begin
      case (op)
        REQ_REGISTER: begin
          // full table wins over the duplicate test
          if (code == '0) begin
            r.status = ST_INVALID;
          end else if (n_entries >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else if (slot_of(code) >= 0) begin
            r.status = ST_INVALID;
          end else begin
            code_mem[n_entries]   = code;
            status_mem[n_entries] = '0;
            sev_mem[n_entries]    = sev;
            n_entries++;
          end
        end
        REQ_FIND: begin
          pos = slot_of(code);
          if (pos < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.code        = code_mem[pos];
            r.entry_state = status_mem[pos];
            r.severity    = sev_mem[pos];
            r.hit         = pos[6:0];
          end
        end
        REQ_SET: begin
          pos = slot_of(code);
          if (pos < 0) r.status = ST_NOT_FOUND;
          else status_mem[pos] = nstat;
        end
        REQ_CLEAR: begin
          for (int unsigned i = 0; i < n_entries && i < TABLE_DEPTH; i++) status_mem[i] = '0;
        end
        REQ_COUNT: begin
          for (int unsigned i = 0; i < n_entries && i < TABLE_DEPTH; i++) begin
            if ((status_mem[i] & mask) != '0) r.count++;
          end
        end
        REQ_GET_IDX: begin
          if (idx >= n_entries || idx >= TABLE_DEPTH) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.code        = code_mem[idx];
            r.entry_state = status_mem[idx];
          end
        end
        default: begin
          r.count = n_entries[7:0];
        end
      endcase
    end
    return r;
  endfunction

  // Count a mismatch; print only the first few
  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) log_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // Predict on each request transaction, compare on each result transaction
  always @(posedge clk) begin : track
    table_result_t want;
    table_result_t got;
    if (rst) begin
      table_on   = 1'b0;
      n_entries  = 0;
      mismatches = '0;
      expected_responses.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_responses.push_back(predict_table_response(req_t'(s_tuser), s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got.status      = res_t'(m_tdata[2:0]);
        got.code        = m_tdata[34:3];
        got.entry_state = m_tdata[42:35];
        got.severity    = m_tdata[50:43];
        got.hit         = m_tdata[57:51];
        got.count       = m_tdata[65:58];
        if (expected_responses.size() == 0) begin
          log_mismatch($sformatf("result 0x%0h with none expected", m_tdata));
        end else begin
          want = expected_responses.pop_front();
          cmp_field("result_status", 32'(want.status), 32'(got.status));
          cmp_field("result_code", want.code, got.code);
          cmp_field("result_entry_state", 32'(want.entry_state), 32'(got.entry_state));
          cmp_field("result_severity", 32'(want.severity), 32'(got.severity));
          cmp_field("hit_index", 32'(want.hit), 32'(got.hit));
          cmp_field("result_count", 32'(want.count), 32'(got.count));
        end
      end
    end
    pending = expected_responses.size();
  end

endmodule

>>> dv/fault_code_status_table_unit_tb.sv
// Testbench top for the fault code status table: stimulus, idling and verdict.
`timescale 1ns / 1ps

module fault_code_status_table_unit_tb;
  import fcst_pkg::*;

  localparam int unsigned PHASE_ITEMS = 350;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0]     s_tuser = REQ_INIT;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [31:0]          mismatches;
  logic [31:0]          pending;

  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 65;
  logic [31:0] sent_codes[$];

  always #10 clk = ~clk;

  fault_code_status_table_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  fcst_result_checker #(.TABLE_DEPTH(128)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Drive one request transaction; valid stays high unless an idle gap is taken
  task automatic send_req(req_t op, logic [31:0] code, logic [7:0] sev, logic [7:0] nstat,
                          logic [7:0] mask, logic [6:0] idx);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, idx, mask, nstat, sev, code};
    if (op == REQ_REGISTER && code != '0) sent_codes.push_back(code);
    do @(posedge clk); while (!s_tready);
  endtask

  // Pick a code that was sent before, or a fresh one
  function automatic logic [31:0] pick_code(int unsigned known_pct);
    if (sent_codes.size() != 0 && $urandom_range(0, 99) < known_pct) begin
      return sent_codes[$urandom_range(0, sent_codes.size() - 1)];
    end
    return $urandom();
  endfunction

  // Mostly well-formed traffic on a growing table, with some noise
  task automatic random_request();
    int unsigned roll;
    int unsigned sel;
    int unsigned span;
    req_t        op;
    logic [31:0] code;
    logic [6:0]  idx;
    roll = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    code = $urandom();
    idx  = 7'($urandom_range(0, 127));
    if (roll < 2) begin
      op = REQ_INIT;
    end else if (roll < 22) begin
      op = REQ_REGISTER;
      if (sel == 0) code = '0;
      else if (sel == 1) code = pick_code(100);
      else if (code == '0) code = 32'h1;
    end else if (roll < 40) begin
      op   = REQ_FIND;
      code = pick_code(75);
    end else if (roll < 55) begin
      op   = REQ_SET;
      code = pick_code(75);
    end else if (roll < 60) begin
      op = REQ_CLEAR;
    end else if (roll < 72) begin
      op = REQ_COUNT;
    end else if (roll < 90) begin
      op = REQ_GET_IDX;
      span = (sent_codes.size() > 128) ? 128 : sent_codes.size();
      if (span != 0 && sel < 8) idx = 7'($urandom_range(0, span - 1));
    end else begin
      op = REQ_GET_CNT;
    end
    send_req(op, code, 8'($urandom()), 8'($urandom()), 8'($urandom()), idx);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hit every request kind but enable before the table is enabled
    send_req(REQ_REGISTER, 32'h1234, 8'h01, 8'h00, 8'h00, 7'd0);
    send_req(REQ_FIND, 32'h1234, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_SET, 32'h1234, 8'h00, 8'hff, 8'h00, 7'd0);
    send_req(REQ_CLEAR, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_COUNT, 32'h0, 8'h00, 8'h00, 8'hff, 7'd0);
    send_req(REQ_GET_IDX, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_GET_CNT, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);

    // Enable, then enable again
    send_req(REQ_INIT, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_INIT, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 7'd127);

    // Empty table reads
    send_req(REQ_GET_CNT, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_GET_IDX, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_COUNT, 32'h0, 8'h00, 8'h00, 8'hff, 7'd0);

    // Register: reserved code, extremes, duplicate
    send_req(REQ_REGISTER, 32'h0, 8'h55, 8'h00, 8'h00, 7'd0);
    send_req(REQ_REGISTER, 32'hffff_ffff, 8'hff, 8'h00, 8'h00, 7'd0);
    send_req(REQ_REGISTER, 32'h1, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_REGISTER, 32'hffff_ffff, 8'h12, 8'h00, 8'h00, 7'd0);

    // Find and update present and absent codes
    send_req(REQ_FIND, 32'hffff_ffff, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_FIND, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_SET, 32'hffff_ffff, 8'h00, 8'hff, 8'h00, 7'd0);
    send_req(REQ_SET, 32'hdead_beef, 8'h00, 8'h0f, 8'h00, 7'd0);
    send_req(REQ_COUNT, 32'h0, 8'h00, 8'h00, 8'h80, 7'd0);
    send_req(REQ_COUNT, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);

    // Index reads inside and past the table, then clear
    send_req(REQ_GET_IDX, 32'h0, 8'h00, 8'h00, 8'h00, 7'd1);
    send_req(REQ_GET_IDX, 32'h0, 8'h00, 8'h00, 8'h00, 7'd127);
    send_req(REQ_CLEAR, 32'h0, 8'h00, 8'h00, 8'h00, 7'd0);
    send_req(REQ_COUNT, 32'h0, 8'h00, 8'h00, 8'hff, 7'd0);

    // Random traffic under three idling mixes
    repeat (PHASE_ITEMS) random_request();
    send_idle_pct = 65;
    recv_idle_pct = 25;
    repeat (PHASE_ITEMS) random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ITEMS) random_request();
    s_tvalid <= 1'b0;

    // Drain outstanding results, then allow for the longest table walk
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
